@@ rtl/core/optical_fork_speed_meter_macros.svh @@
// Assertion macros shared by the speed meter RTL.
// Included by files that check their own control logic; no other dependencies.
`ifndef OPTICAL_FORK_SPEED_METER_MACROS_SVH
`define OPTICAL_FORK_SPEED_METER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OFSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ofsm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define OFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ofsm: next-cycle check failed");

`endif

@@ rtl/core/ofsm_pkg.sv @@
// Shared types and constants of the optical fork speed meter.
// Holds register widths, reset values, register indexes, FSM state and control structs.
package ofsm_pkg;

	localparam int NUM_W      = 14;
	localparam int STEP_W     = 20;
	localparam int ALPHA_W    = 16;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUMERATOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_STEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA           = 2'd2;

	localparam logic [NUM_W-1:0]   NUM_RESET   = 14'd10000;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 20'd10000;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;
	localparam logic [ALPHA_W:0]   ALPHA_ONE   = 17'h10000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CHECK,
		ST_START,
		ST_DIV,
		ST_MUL_OLD,
		ST_MUL_NEW,
		ST_MIX,
		ST_SET,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic set_limit;
		logic div_start;
		logic mul_old;
		logic mul_new;
		logic mix;
		logic set_inst;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_edge;
		logic timeout;
		logic div_done;
		logic edge_q;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/core/ofsm_channels.sv @@
// Request channels of the optical fork speed meter: sample input and result output.
// Each carries valid, ready and its payload; widths follow the block parameters.
interface ofsm_sample_if #(parameter int TIME_BITS = 32);
	logic                 valid;
	logic                 ready;
	logic                 sensor_level;
	logic [TIME_BITS-1:0] timestamp_us;

	modport source (output valid, sensor_level, timestamp_us, input ready);
	modport sink (input valid, sensor_level, timestamp_us, output ready);
endinterface

interface ofsm_result_if #(parameter int SPEED_BITS = 30, parameter int TIME_BITS = 32);
	logic                  valid;
	logic                  ready;
	logic [SPEED_BITS-1:0] speed_q16;
	logic [TIME_BITS-1:0]  interval_us;
	logic                  edge_seen;

	modport source (output valid, speed_q16, interval_us, edge_seen, input ready);
	modport sink (input valid, speed_q16, interval_us, edge_seen, output ready);
endinterface

@@ rtl/core/ofsm_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; a zero divisor yields an all-ones quotient.
module ofsm_div #(
	parameter int DIVIDEND_W = 30,
	parameter int DIVISOR_W  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      count_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVIDEND_W-1:0] quot_q;
	logic [DIVISOR_W:0]    rem_shift;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	always_comb begin
		rem_shift = {rem_q, num_q[DIVIDEND_W-1]};
		fits      = rem_shift >= {1'b0, den_q};
		diff      = rem_shift - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			count_q <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			count_q <= count_q - 1'b1;
			if (count_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
			num_q  <= {num_q[DIVIDEND_W-2:0], 1'b0};
			quot_q <= {quot_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quot_q;

endmodule

@@ rtl/core/ofsm_ctrl.sv @@
// Sequencing state machine of the speed meter.
// Depends on ofsm_pkg for the state type and the command and status structs.
module ofsm_ctrl
	import ofsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = status.is_edge ? ST_START : ST_CHECK;
			end
			ST_CHECK: begin
				state_d = status.timeout ? ST_START : ST_OUT;
			end
			ST_START: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) state_d = status.edge_q ? ST_MUL_OLD : ST_SET;
			end
			ST_MUL_OLD: begin
				state_d = ST_MUL_NEW;
			end
			ST_MUL_NEW: begin
				state_d = ST_MIX;
			end
			ST_MIX: begin
				state_d = ST_OUT;
			end
			ST_SET: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			ST_CHECK: begin
				cmd.set_limit = status.timeout;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
			end
			ST_MUL_OLD: begin
				cmd.mul_old = 1'b1;
			end
			ST_MUL_NEW: begin
				cmd.mul_new = 1'b1;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
			end
			ST_SET: begin
				cmd.set_inst = 1'b1;
			end
			ST_OUT: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/core/ofsm_dp.sv @@
// Datapath of the speed meter: edge state, interval limit, divider, smoothing, result register.
// Depends on ofsm_pkg, ofsm_div and the shared assertion macros.
`include "optical_fork_speed_meter_macros.svh"

module ofsm_dp
	import ofsm_pkg::*;
#(
	parameter int TIME_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ctrl_cmd_t                      cmd,
	output dp_status_t                     status,
	input  logic                           sensor_level,
	input  logic [TIME_BITS-1:0]           timestamp_us,
	input  logic [NUM_W-1:0]               speed_numerator,
	input  logic [STEP_W-1:0]              timeout_step_us,
	input  logic [ALPHA_W-1:0]             alpha_q16,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [NUM_W+FRAC_BITS-1:0]     out_speed,
	output logic [TIME_BITS-1:0]           out_interval,
	output logic                           out_edge_seen
);

	localparam int SPEED_BITS = NUM_W + FRAC_BITS;
	localparam int SUM_W      = (TIME_BITS > STEP_W ? TIME_BITS : STEP_W) + 1;
	localparam int OLD_W      = ALPHA_W + SPEED_BITS;
	localparam int NEW_W      = ALPHA_W + 1 + SPEED_BITS;
	localparam int MIX_W      = NEW_W + 1;
	localparam int SHIFT_W    = MIX_W - ALPHA_W;
	localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

	logic                  level_q;
	logic [TIME_BITS-1:0]  time_q;
	logic                  lwh_q;
	logic [TIME_BITS-1:0]  last_edge_q;
	logic [TIME_BITS-1:0]  period_q;
	logic [SPEED_BITS-1:0] smoothed_q;
	logic                  edge_q;
	logic [TIME_BITS-1:0]  elapsed_q;
	logic [TIME_BITS-1:0]  limit_q;
	logic [OLD_W-1:0]      prod_old_q;
	logic [NEW_W-1:0]      prod_new_q;
	logic                  out_valid_q;
	logic [SPEED_BITS-1:0] out_speed_q;
	logic [TIME_BITS-1:0]  out_interval_q;
	logic                  out_edge_q;

	logic [TIME_BITS-1:0]  elapsed;
	logic                  is_edge;
	logic [SUM_W-1:0]      limit_sum;
	logic [TIME_BITS-1:0]  limit;
	logic [ALPHA_W:0]      weight_new;
	logic [MIX_W-1:0]      mix_sum;
	logic [SHIFT_W-1:0]    mix_shift;
	logic [SPEED_BITS-1:0] mix_sat;
	logic [SPEED_BITS-1:0] quot;
	logic                  div_busy;
	logic                  div_done;
	logic                  out_free;

	ofsm_div #(
		.DIVIDEND_W (SPEED_BITS),
		.DIVISOR_W  (TIME_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({speed_numerator, {FRAC_BITS{1'b0}}}),
		.divisor  (period_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		elapsed    = time_q - last_edge_q;
		is_edge    = level_q & ~lwh_q;
		limit_sum  = SUM_W'(period_q) + SUM_W'(timeout_step_us);
		limit      = (limit_sum[SUM_W-1:TIME_BITS] != '0) ? {TIME_BITS{1'b1}}
			: limit_sum[TIME_BITS-1:0];
		weight_new = ALPHA_ONE - {1'b0, alpha_q16};
		mix_sum    = MIX_W'(prod_old_q) + MIX_W'(prod_new_q);
		mix_shift  = mix_sum[MIX_W-1:ALPHA_W];
		mix_sat    = (mix_shift > SHIFT_W'(SPEED_MAX)) ? SPEED_MAX : mix_shift[SPEED_BITS-1:0];
		out_free   = ~out_valid_q | out_ready;
	end

	always_comb begin
		status          = '0;
		status.is_edge  = is_edge;
		status.timeout  = elapsed_q > limit_q;
		status.div_done = div_done;
		status.edge_q   = edge_q;
		status.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lwh_q       <= 1'b1;
			last_edge_q <= '0;
			period_q    <= '0;
			smoothed_q  <= '0;
			edge_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				lwh_q  <= level_q;
				edge_q <= is_edge;
				if (is_edge) begin
					period_q    <= elapsed;
					last_edge_q <= time_q;
				end
			end
			if (cmd.set_limit) period_q <= limit_q;
			if (cmd.mix) smoothed_q <= mix_sat;
			if (cmd.set_inst) smoothed_q <= quot;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			level_q <= sensor_level;
			time_q  <= timestamp_us;
		end
		if (cmd.eval) begin
			elapsed_q <= elapsed;
			limit_q   <= limit;
		end
		if (cmd.mul_old) prod_old_q <= OLD_W'(alpha_q16) * OLD_W'(smoothed_q);
		if (cmd.mul_new) prod_new_q <= NEW_W'(weight_new) * NEW_W'(quot);
		if (cmd.out_load) begin
			out_speed_q    <= smoothed_q;
			out_interval_q <= period_q;
			out_edge_q     <= edge_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_speed     = out_speed_q;
	assign out_interval  = out_interval_q;
	assign out_edge_seen = out_edge_q;

	`OFSM_ASSERT_IMP(a_div_idle_on_start, clk, arst_n, cmd.div_start, !div_busy)
	`OFSM_ASSERT_IMP(a_no_result_overwrite, clk, arst_n, cmd.out_load, out_free)
	`OFSM_ASSERT_NEXT(a_edge_rearm, clk, arst_n, cmd.eval && is_edge, last_edge_q == time_q && lwh_q)
	`OFSM_ASSERT_IMP(a_mix_after_edge, clk, arst_n, cmd.mix, edge_q)

endmodule

@@ rtl/core/optical_fork_speed_meter.sv @@
// Optical fork speed meter top level: config registers, controller and datapath.
// Path per sample from IDLE (DIV runs the bit-serial divider): EVAL, CHECK, OUT with
// no edge and no timeout; EVAL, CHECK, START, DIV, SET, OUT on a timeout; EVAL, START, DIV,
// MUL_OLD, MUL_NEW, MIX, OUT on an edge. Samples wait for IDLE; a held result stalls OUT.
// Reset (arst_n low): config to 10000 / 10000 / 3277, flag set, interval and speed zero.
// Depends on ofsm_pkg, ofsm_channels, ofsm_ctrl and ofsm_dp.
module optical_fork_speed_meter
	import ofsm_pkg::*;
#(
	parameter int TIME_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ofsm_sample_if.sink           sample,
	ofsm_result_if.source         result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [NUM_W-1:0]   numerator_q;
	logic [STEP_W-1:0]  step_q;
	logic [ALPHA_W-1:0] alpha_q;
	ctrl_cmd_t          cmd;
	dp_status_t         status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q <= NUM_RESET;
			step_q      <= STEP_RESET;
			alpha_q     <= ALPHA_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_SPEED_NUMERATOR: numerator_q <= cfg_wdata[NUM_W-1:0];
				REG_TIMEOUT_STEP:    step_q      <= cfg_wdata[STEP_W-1:0];
				REG_ALPHA:           alpha_q     <= cfg_wdata[ALPHA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ofsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ofsm_dp #(
		.TIME_BITS (TIME_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.sensor_level    (sample.sensor_level),
		.timestamp_us    (sample.timestamp_us),
		.speed_numerator (numerator_q),
		.timeout_step_us (step_q),
		.alpha_q16       (alpha_q),
		.out_ready       (result.ready),
		.out_valid       (result.valid),
		.out_speed       (result.speed_q16),
		.out_interval    (result.interval_us),
		.out_edge_seen   (result.edge_seen)
	);

endmodule

@@ bench/optical_fork_speed_meter_tb.sv @@
`timescale 1ns / 1ps
// Testbench of optical_fork_speed_meter: drives photodiode samples through the sample
// channel, checks every reading against an in-bench tachometer predictor or typed rows.
// Depends on ofsm_pkg, ofsm_channels and the speed meter RTL.
module optical_fork_speed_meter_tb;
	import ofsm_pkg::*;

	localparam int TIME_BITS  = 32;
	localparam int FRAC_BITS  = 16;
	localparam int SPEED_BITS = 14 + FRAC_BITS;
	localparam logic [63:0] SPEED_MAX = (64'd1 << SPEED_BITS) - 64'd1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int NUM_PHASES    = 8;
	localparam int PHASE_ITEMS   = 90;
	localparam int NUM_ROWS      = 23;

	typedef struct packed {
		logic [SPEED_BITS-1:0] speed;
		logic [TIME_BITS-1:0]  interval;
		logic                  edge_seen;
	} reading_t;

	typedef struct packed {
		logic                 lvl;
		logic [TIME_BITS-1:0] ts;
		logic                 typed;
		reading_t             want;
	} sample_row_t;

	localparam sample_row_t DIRECTED [NUM_ROWS] = '{
		'{1'b1, 32'd0,          1'b1, '{30'd0,         32'd0,     1'b0}},
		'{1'b0, 32'd5,          1'b1, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'd5,          1'b1, '{30'd124518000, 32'd5,     1'b1}},
		'{1'b1, 32'd6,          1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b0, 32'd5,          1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'd5,          1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'd10006,      1'b1, '{30'd65536,     32'd10000, 1'b0}},
		'{1'b1, 32'd20007,      1'b1, '{30'd32768,     32'd20000, 1'b0}},
		'{1'b0, 32'd1,          1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'd2,          1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'd1,          1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b0, 32'hFFFF_FFFF,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'd0,          1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b0, 32'hFFFF_FFFF,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'hFFFF_FFFF,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b0, 32'h8000_0000,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'h8000_0000,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'h8000_0001,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b0, 32'h8000_0001,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'h8000_0001,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b0, 32'h8000_0002,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'h8000_0003,  1'b0, '{30'd0,         32'd0,     1'b0}},
		'{1'b1, 32'h8000_7533,  1'b0, '{30'd0,         32'd0,     1'b0}}
	};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ofsm_sample_if #(.TIME_BITS(TIME_BITS)) sample_ch ();
	ofsm_result_if #(.SPEED_BITS(SPEED_BITS), .TIME_BITS(TIME_BITS)) result_ch ();

	optical_fork_speed_meter #(
		.TIME_BITS(TIME_BITS),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	logic [NUM_W-1:0]      num_reg;
	logic [STEP_W-1:0]     step_reg;
	logic [ALPHA_W-1:0]    alpha_reg;
	logic                  seen_high;
	logic [TIME_BITS-1:0]  last_edge_ts;
	logic [TIME_BITS-1:0]  period_reg;
	logic [SPEED_BITS-1:0] speed_reg;

	reading_t pending_readings[$];
	int  error_count = 0;
	int  cycle_count = 0;
	bit  no_idle = 1'b0;

	function automatic logic [SPEED_BITS-1:0] speed_of_interval(input logic [TIME_BITS-1:0] ivl);
		logic [63:0] q;
		if (ivl == '0)
			return SPEED_MAX[SPEED_BITS-1:0];
		q = (64'(num_reg) << FRAC_BITS) / 64'(ivl);
		if (q > SPEED_MAX)
			return SPEED_MAX[SPEED_BITS-1:0];
		return q[SPEED_BITS-1:0];
	endfunction

	function automatic reading_t meter_step(input logic lvl, input logic [TIME_BITS-1:0] ts);
		reading_t r;
		logic [63:0] mix;
		logic [SPEED_BITS-1:0] inst;
		logic [TIME_BITS-1:0] elapsed;
		logic [TIME_BITS-1:0] lim;
		r.edge_seen = 1'b0;
		if (!lvl)
			seen_high = 1'b0;
		if (lvl && !seen_high) begin
			seen_high = 1'b1;
			period_reg = ts - last_edge_ts;
			inst = speed_of_interval(period_reg);
			mix = 64'(alpha_reg) * 64'(speed_reg)
				+ (64'd65536 - 64'(alpha_reg)) * 64'(inst);
			mix = mix >> 16;
			speed_reg = (mix > SPEED_MAX) ? SPEED_MAX[SPEED_BITS-1:0] : mix[SPEED_BITS-1:0];
			last_edge_ts = ts;
			r.edge_seen = 1'b1;
		end
		elapsed = ts - last_edge_ts;
		if (period_reg > TIME_MAX - TIME_BITS'(step_reg))
			lim = TIME_MAX;
		else
			lim = period_reg + TIME_BITS'(step_reg);
		if (elapsed > lim) begin
			period_reg = lim;
			speed_reg = speed_of_interval(period_reg);
		end
		r.speed = speed_reg;
		r.interval = period_reg;
		return r;
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_SPEED_NUMERATOR: num_reg = data[NUM_W-1:0];
			REG_TIMEOUT_STEP:    step_reg = data[STEP_W-1:0];
			REG_ALPHA:           alpha_reg = data[ALPHA_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic program_phase(input int p);
		case (p)
			1: begin
				cfg_write(REG_SPEED_NUMERATOR, 20'd16383);
				cfg_write(REG_TIMEOUT_STEP, 20'd1);
				cfg_write(REG_ALPHA, 20'd0);
			end
			2: begin
				cfg_write(REG_SPEED_NUMERATOR, 20'd0);
				cfg_write(REG_TIMEOUT_STEP, 20'd0);
				cfg_write(REG_ALPHA, 20'd65535);
			end
			3: begin
				cfg_write(REG_SPEED_NUMERATOR, 20'd1);
				cfg_write(REG_TIMEOUT_STEP, 20'd1000000);
				cfg_write(REG_ALPHA, 20'd32768);
			end
			4: begin
				cfg_write(REG_UNUSED, CFG_DATA_W'($urandom()));
				cfg_write(REG_SPEED_NUMERATOR, CFG_DATA_W'($urandom()));
				cfg_write(REG_TIMEOUT_STEP, 20'hFFFFF);
				cfg_write(REG_ALPHA, CFG_DATA_W'($urandom()));
			end
			default: begin
				cfg_write(REG_SPEED_NUMERATOR, CFG_DATA_W'($urandom()));
				cfg_write(REG_TIMEOUT_STEP, CFG_DATA_W'($urandom_range(0, 20000)));
				cfg_write(REG_ALPHA, CFG_DATA_W'($urandom()));
			end
		endcase
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_sample(input logic lvl, input logic [TIME_BITS-1:0] ts,
			input logic use_typed, input reading_t typed_val);
		reading_t r;
		while (!no_idle && $urandom_range(0, 99) < 20) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.sensor_level <= lvl;
		sample_ch.timestamp_us <= ts;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		r = meter_step(lvl, ts);
		pending_readings.push_back(use_typed ? typed_val : r);
		@(negedge clk);
	endtask

	task automatic drain_readings();
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= no_idle || ($urandom_range(0, 99) >= 20);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("optical_fork_speed_meter_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected reading speed=%0d interval=%0d edge=%0b", $time,
					result_ch.speed_q16, result_ch.interval_us, result_ch.edge_seen);
				error_count++;
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.speed_q16 !== want.speed) begin
					$display("%0t: speed_q16 expected %0d actual %0d", $time,
						want.speed, result_ch.speed_q16);
					error_count++;
				end
				if (result_ch.interval_us !== want.interval) begin
					$display("%0t: interval_us expected %0d actual %0d", $time,
						want.interval, result_ch.interval_us);
					error_count++;
				end
				if (result_ch.edge_seen !== want.edge_seen) begin
					$display("%0t: edge_seen expected %0b actual %0b", $time,
						want.edge_seen, result_ch.edge_seen);
					error_count++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [TIME_BITS-1:0] cursor;
		logic [TIME_BITS-1:0] ts;
		logic                 cur_lvl;
		logic                 lvl;
		int                   gap_scale;
		int                   r;

		arst_n                 <= 1'b0;
		cfg_wr_en              <= 1'b0;
		cfg_addr               <= REG_SPEED_NUMERATOR;
		cfg_wdata              <= '0;
		sample_ch.valid        <= 1'b0;
		sample_ch.sensor_level <= 1'b0;
		sample_ch.timestamp_us <= '0;
		num_reg      = NUM_RESET;
		step_reg     = STEP_RESET;
		alpha_reg    = ALPHA_RESET;
		seen_high    = 1'b1;
		last_edge_ts = '0;
		period_reg   = '0;
		speed_reg    = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_ROWS; i++)
			send_sample(DIRECTED[i].lvl, DIRECTED[i].ts, DIRECTED[i].typed, DIRECTED[i].want);

		cursor  = $urandom();
		cur_lvl = 1'b0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				sample_ch.valid <= 1'b0;
				drain_readings();
				program_phase(p);
			end
			no_idle = (p == 4);
			case ($urandom_range(0, 2))
				0: gap_scale = 40;
				1: gap_scale = 3000;
				default: gap_scale = 40000;
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == PHASE_ITEMS / 2) begin
					sample_ch.valid <= 1'b0;
					drain_readings();
				end
				r = $urandom_range(0, 99);
				if (r < 10) begin
					lvl = 1'($urandom_range(0, 1));
					ts  = $urandom();
				end else begin
					if (r < 20) begin
						lvl = cur_lvl;
						cursor = cursor + $urandom_range(0, 2 * int'(step_reg) + 2000);
					end else begin
						lvl = (r < 70) ? ~cur_lvl : cur_lvl;
						cursor = cursor + $urandom_range(0, gap_scale);
					end
					cur_lvl = lvl;
					ts = cursor;
				end
				send_sample(lvl, ts, 1'b0, '0);
			end
		end

		no_idle = 1'b0;
		sample_ch.valid <= 1'b0;
		drain_readings();
		if (error_count == 0)
			$display("optical_fork_speed_meter_tb: clean");
		else
			$display("optical_fork_speed_meter_tb: errors");
		$finish;
	end
endmodule
